### rtl/olte_pkg.sv
package olte_pkg;

    localparam int WORD_W   = 32;
    localparam int FUNC_W   = 3;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 2;
    localparam int LOC_W    = 4;
    localparam int CNT_W    = 5;

    localparam logic [FUNC_W-1:0] OP_APPEND = 3'd0;
    localparam logic [FUNC_W-1:0] OP_SEARCH = 3'd1;
    localparam logic [FUNC_W-1:0] OP_INSERT = 3'd2;
    localparam logic [FUNC_W-1:0] OP_DELETE = 3'd3;
    localparam logic [FUNC_W-1:0] OP_READ   = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_BADPOS   = 2'd3;

    typedef struct packed {
        logic load;
        logic take_left;
        logic take_right;
    } cell_ctl_t;

endpackage

### rtl/olte_cell.sv
module olte_cell (
    input  logic                            clk,
    input  logic                            capture,
    input  logic                            in_use,
    input  logic [olte_pkg::WORD_W-1:0]     key,
    input  logic [olte_pkg::WORD_W-1:0]     load_word,
    input  olte_pkg::cell_ctl_t             ctl,
    input  logic [olte_pkg::WORD_W-1:0]     left_word,
    input  logic [olte_pkg::WORD_W-1:0]     right_word,
    output logic [olte_pkg::WORD_W-1:0]     word,
    output logic                            match
);

    logic [olte_pkg::WORD_W-1:0] word_reg;
    logic                        match_reg;

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            match_reg <= in_use && (word_reg == key);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            word_reg <= load_word;
        end
        else if (ctl.take_left)
        begin
            word_reg <= left_word;
        end
        else if (ctl.take_right)
        begin
            word_reg <= right_word;
        end
    end

    assign word  = word_reg;
    assign match = match_reg;

endmodule

### rtl/ordered_list_table_engine.sv
// Ordered list of up to DEPTH signed words kept in a row of cells, one word per cell.
// A transaction is accepted when start is high and busy is low; busy then stays high
// for one cycle. In the accept cycle each cell compares its word with the key and
// registers the match; in the busy cycle the cells shift or load in parallel and the
// result is registered. The result appears on the outputs with done high for exactly one
// cycle, in the cycle after busy, and the receiver cannot stall it; a new transaction may be
// started in that same cycle. The count and location outputs carry the low bits of the
// internal values when DEPTH exceeds their widths.
module ordered_list_table_engine #(
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     start,
    output logic                                     busy,
    input  logic        [olte_pkg::FUNC_W-1:0]       func,
    input  logic        [olte_pkg::POS_W-1:0]        position,
    input  logic signed [olte_pkg::WORD_W-1:0]       value,
    output logic                                     done,
    output logic        [olte_pkg::STATUS_W-1:0]     status,
    output logic        [olte_pkg::LOC_W-1:0]        location,
    output logic signed [olte_pkg::WORD_W-1:0]       data,
    output logic        [olte_pkg::CNT_W-1:0]        count
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int CMP_W = (CW > olte_pkg::POS_W) ? CW : olte_pkg::POS_W;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic                               state_reg;
    logic                               state_next;
    logic [olte_pkg::FUNC_W-1:0]        func_reg;
    logic [olte_pkg::POS_W-1:0]         pos_reg;
    logic [olte_pkg::WORD_W-1:0]        value_reg;
    logic [CW-1:0]                      count_reg;
    logic [CW-1:0]                      count_next;
    logic                               done_reg;
    logic [olte_pkg::STATUS_W-1:0]      status_reg;
    logic [olte_pkg::STATUS_W-1:0]      status_next;
    logic [olte_pkg::LOC_W-1:0]         location_reg;
    logic [olte_pkg::LOC_W-1:0]         location_next;
    logic [olte_pkg::WORD_W-1:0]        data_reg;
    logic [olte_pkg::WORD_W-1:0]        data_next;

    logic                               accept;
    logic [DEPTH-1:0]                   match_vec;
    logic [DEPTH-1:0]                   in_use_vec;
    logic [DEPTH-1:0]                   at_or_after;
    logic [IDX_W-1:0]                   first_idx;
    logic                               found;
    logic                               full;
    logic [CMP_W-1:0]                   pos_ext;
    logic [CMP_W-1:0]                   cnt_ext;
    logic                               ins_ok;
    logic                               app_ok;
    logic                               del_ok;
    logic                               read_ok;
    logic [olte_pkg::WORD_W-1:0]        words [DEPTH];
    olte_pkg::cell_ctl_t                ctl [DEPTH];

    assign accept  = start && (state_reg == S_IDLE);
    assign pos_ext = CMP_W'(pos_reg);
    assign cnt_ext = CMP_W'(count_reg);
    assign full    = (count_reg == CW'(DEPTH));
    assign found   = |match_vec;
    assign app_ok  = (func_reg == olte_pkg::OP_APPEND) && !full;
    assign ins_ok  = (func_reg == olte_pkg::OP_INSERT) && !full && (pos_ext <= cnt_ext);
    assign del_ok  = (func_reg == olte_pkg::OP_DELETE) && found;
    assign read_ok = (pos_ext < cnt_ext);

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            in_use_vec[i] = (CMP_W'(i) < cnt_ext);
        end
    end

    always_comb
    begin
        logic acc;
        acc       = 1'b0;
        first_idx = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (match_vec[i] && !acc)
            begin
                first_idx = IDX_W'(i);
            end
            acc            = acc | match_vec[i];
            at_or_after[i] = acc;
        end
    end

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            ctl[i].load = (state_reg == S_EXEC)
                && ((ins_ok && (pos_ext == CMP_W'(i)))
                    || (app_ok && (cnt_ext == CMP_W'(i))));
            ctl[i].take_left = (state_reg == S_EXEC) && (i > 0) && ins_ok
                && (CMP_W'(i) > pos_ext) && (CMP_W'(i) <= cnt_ext);
            ctl[i].take_right = (state_reg == S_EXEC) && (i < DEPTH - 1) && del_ok
                && at_or_after[i];
        end
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic [olte_pkg::WORD_W-1:0] left_w;
            logic [olte_pkg::WORD_W-1:0] right_w;

            if (g == 0)
            begin : g_first
                assign left_w = '0;
            end
            else
            begin : g_mid_l
                assign left_w = words[g-1];
            end

            if (g == DEPTH - 1)
            begin : g_last
                assign right_w = '0;
            end
            else
            begin : g_mid_r
                assign right_w = words[g+1];
            end

            olte_cell u_cell (
                .clk        (clk),
                .capture    (accept),
                .in_use     (in_use_vec[g]),
                .key        (value),
                .load_word  (value_reg),
                .ctl        (ctl[g]),
                .left_word  (left_w),
                .right_word (right_w),
                .word       (words[g]),
                .match      (match_vec[g])
            );
        end
    endgenerate

    always_comb
    begin
        status_next   = olte_pkg::STATUS_OK;
        location_next = '0;
        data_next     = '0;
        count_next    = count_reg;
        unique case (func_reg)
            olte_pkg::OP_APPEND:
            begin
                if (full)
                begin
                    status_next = olte_pkg::STATUS_FULL;
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                end
            end
            olte_pkg::OP_SEARCH:
            begin
                if (found)
                begin
                    location_next = olte_pkg::LOC_W'(first_idx);
                end
                else
                begin
                    status_next = olte_pkg::STATUS_NOTFOUND;
                end
            end
            olte_pkg::OP_INSERT:
            begin
                if (full)
                begin
                    status_next = olte_pkg::STATUS_FULL;
                end
                else if (pos_ext > cnt_ext)
                begin
                    status_next = olte_pkg::STATUS_BADPOS;
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                end
            end
            olte_pkg::OP_DELETE:
            begin
                if (found)
                begin
                    location_next = olte_pkg::LOC_W'(first_idx);
                    count_next    = count_reg - CW'(1);
                end
                else
                begin
                    status_next = olte_pkg::STATUS_NOTFOUND;
                end
            end
            olte_pkg::OP_READ:
            begin
                if (read_ok)
                begin
                    data_next = words[IDX_W'(pos_reg)];
                end
                else
                begin
                    status_next = olte_pkg::STATUS_BADPOS;
                end
            end
            default:
            begin
                status_next = olte_pkg::STATUS_BADPOS;
            end
        endcase
    end

    always_comb
    begin
        unique case (state_reg)
            S_IDLE:  state_next = accept ? S_EXEC : S_IDLE;
            S_EXEC:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_EXEC);
            if (state_reg == S_EXEC)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg  <= func;
            pos_reg   <= position;
            value_reg <= value;
        end
        if (state_reg == S_EXEC)
        begin
            status_reg   <= status_next;
            location_reg <= location_next;
            data_reg     <= data_next;
        end
    end

    assign busy     = (state_reg == S_EXEC);
    assign done     = done_reg;
    assign status   = status_reg;
    assign location = location_reg;
    assign data     = data_reg;
    assign count    = olte_pkg::CNT_W'(count_reg);

    a_exec_then_done : assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done)
        else $error("busy cycle not followed by a result strobe");

    a_accept_then_busy : assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not enter the execute cycle");

    a_done_not_busy : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while still busy");

    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count exceeds depth");

    a_fail_keeps_count : assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != olte_pkg::STATUS_OK)) |-> (count == $past(count)))
        else $error("failed transaction changed the entry count");

endmodule
